FILE: rtl/text_console_character_engine_defines.svh
// Assertion macros shared by the console character engine RTL.
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCCE_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tcce: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TCCE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tcce: next-cycle check failed");

`endif

FILE: rtl/tcce_pkg.sv
// Package with widths, codes and constants of the console character engine.
`timescale 1ns / 1ps

package tcce_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Payload widths
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int POS_W    = 11;
    localparam int CELL_W   = 16;
    localparam int COLOR_W  = 4;
    localparam int CFG_IDX_W = 1;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CHR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;

    localparam int TAB_STEP = 8;

    // Cell value after reset: blank, white on black
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

    // Color register defaults and indexes
    localparam logic [COLOR_W-1:0] FORE_RESET = 4'hF;
    localparam logic [COLOR_W-1:0] BACK_RESET = 4'h0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK = 1'd1;

    // Shared arithmetic unit operations
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

FILE: rtl/tcce_cmd_if.sv
// Request channel interface of the console character engine.
`timescale 1ns / 1ps

interface tcce_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [tcce_pkg::ACTION_W-1:0]  action;
    logic [tcce_pkg::CHAR_W-1:0]    char_code;
    logic [tcce_pkg::INDEX_W-1:0]   cell_index;

    modport source (output valid, output action, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input action, input char_code, input cell_index,
                    output ready);
endinterface

FILE: rtl/tcce_rsp_if.sv
// Result channel interface of the console character engine.
`timescale 1ns / 1ps

interface tcce_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tcce_pkg::POS_W-1:0]   cursor_pos;
    logic [tcce_pkg::CELL_W-1:0]  cell_data;

    modport source (output valid, output cursor_pos, output cell_data, input ready);
    modport sink   (input valid, input cursor_pos, input cell_data, output ready);
endinterface

FILE: rtl/tcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/tcce_alu.sv
// Shared add/subtract unit with an unsigned greater-or-equal flag.
`timescale 1ns / 1ps

module tcce_alu #(
    parameter int W = 12
) (
    input  tcce_pkg::alu_op_t op,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output logic [W-1:0]      res,
    output logic              ge
);

    // Compute sum or difference and the compare flag
    always_comb
    begin
        case (op)
            tcce_pkg::ALU_ADD: res = a + b;
            tcce_pkg::ALU_SUB: res = a - b;
            default:           res = a + b;
        endcase
        ge = (a >= b);
    end

endmodule

FILE: rtl/text_console_character_engine.sv
// Top level of the text console character engine: sequencer, cell RAM and shared unit.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------
//  cmd     | in  | valid / ready     | action, char_code, cell_index
//  rsp     | out | valid / ready     | cursor_pos, cell_data
//  cfg     | in  | cfg_we            | cfg_index, cfg_data (fore, back color)
//
//  Put moves the cursor and writes printable bytes; when the line scrolls it adds one blank write
//  per cell of the recycled row, a row-offset register does the rest.
//  Clear blanks every cell, one cell write per cycle on the RAM write port.
//  Read finds the row by repeated subtraction of COLUMNS in the shared unit, then
//  does one registered RAM read.
//  After reset a fill pass writes blank cells; cmd.ready is low.
//  A stalled result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`include "text_console_character_engine_defines.svh"

module text_console_character_engine #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tcce_cmd_if.sink                       cmd,
    tcce_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcce_pkg::COLOR_W-1:0]   cfg_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int ALU_W  = ((ADDR_W > tcce_pkg::INDEX_W) ? ADDR_W : tcce_pkg::INDEX_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_PUT,
        S_SCROLL,
        S_DIV,
        S_RD_ADDR,
        S_RD_DATA,
        S_DONE
    } state_t;

    state_t                          state_reg,     state_next;
    logic [COL_W-1:0]                col_reg,       col_next;
    logic [ROW_W-1:0]                row_reg,       row_next;
    logic [ROW_W-1:0]                top_reg,       top_next;
    logic [tcce_pkg::COLOR_W-1:0]    fore_reg,      fore_next;
    logic [tcce_pkg::COLOR_W-1:0]    back_reg,      back_next;
    logic [tcce_pkg::CELL_W-1:0]     fill_val_reg,  fill_val_next;
    logic                            fill_res_reg,  fill_res_next;
    logic [tcce_pkg::CHAR_W-1:0]     code_reg,      code_next;
    logic [tcce_pkg::INDEX_W-1:0]    rem_reg,       rem_next;
    logic [ROW_W-1:0]                qrow_reg,      qrow_next;
    logic [ADDR_W-1:0]               swp_addr_reg,  swp_addr_next;
    logic [ADDR_W-1:0]               swp_last_reg,  swp_last_next;
    logic [tcce_pkg::CELL_W-1:0]     res_data_reg,  res_data_next;
    logic                            out_valid_reg, out_valid_next;
    logic [tcce_pkg::POS_W-1:0]      out_pos_reg,   out_pos_next;
    logic [tcce_pkg::CELL_W-1:0]     out_data_reg,  out_data_next;

    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr;
    logic [tcce_pkg::CELL_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]               ram_raddr;
    logic [tcce_pkg::CELL_W-1:0]     ram_rdata;

    tcce_pkg::alu_op_t               alu_op;
    logic [ALU_W-1:0]                alu_a;
    logic [ALU_W-1:0]                alu_b;
    logic [ALU_W-1:0]                alu_res;
    logic                            alu_ge;

    logic                            cmd_fire;
    logic [COL_W:0]                  col_w;
    logic                            row_inc;
    logic [ADDR_W-1:0]               scroll_base;
    logic [ADDR_W-1:0]               pos_full;

    // Physical RAM address of a logical cell, rows rotated by the top-row offset
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] r,
        input logic [ROW_W-1:0] t,
        input logic [COL_W-1:0] c
    );
        logic [ROW_W:0]   sum;
        logic [ROW_W-1:0] phys;
        sum = {1'b0, r} + {1'b0, t};
        if (sum >= (ROW_W + 1)'(ROWS))
        begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        phys = sum[ROW_W-1:0];
        return ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcce_alu #(
        .W (ALU_W)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ge  (alu_ge)
    );

    assign cmd.ready      = (state_reg == S_IDLE);
    assign cmd_fire       = cmd.valid && cmd.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.cursor_pos = out_pos_reg;
    assign rsp.cell_data  = out_data_reg;

    // Linear cursor position and base of the row recycled by a scroll
    assign pos_full    = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign scroll_base = ADDR_W'(top_reg) * ADDR_W'(COLUMNS);

    // Sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        top_next       = top_reg;
        fore_next      = fore_reg;
        back_next      = back_reg;
        fill_val_next  = fill_val_reg;
        fill_res_next  = fill_res_reg;
        code_next      = code_reg;
        rem_next       = rem_reg;
        qrow_next      = qrow_reg;
        swp_addr_next  = swp_addr_reg;
        swp_last_next  = swp_last_reg;
        res_data_next  = res_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_pos_next   = out_pos_reg;
        out_data_next  = out_data_reg;

        ram_we    = 1'b0;
        ram_waddr = swp_addr_reg;
        ram_wdata = fill_val_reg;
        ram_raddr = cell_addr(qrow_reg, top_reg, rem_reg[COL_W-1:0]);

        alu_op = tcce_pkg::ALU_ADD;
        alu_a  = ALU_W'(swp_addr_reg);
        alu_b  = ALU_W'(1);

        col_w   = {1'b0, col_reg};
        row_inc = 1'b0;

        // Take color register writes
        if (cfg_we)
        begin
            case (cfg_index)
                tcce_pkg::CFG_FORE: fore_next = cfg_data;
                tcce_pkg::CFG_BACK: back_next = cfg_data;
                default:            ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    code_next     = cmd.char_code;
                    res_data_next = '0;
                    case (cmd.action)
                        tcce_pkg::ACT_PUT:
                        begin
                            state_next = S_PUT;
                        end
                        tcce_pkg::ACT_CLEAR:
                        begin
                            col_next      = '0;
                            row_next      = '0;
                            top_next      = '0;
                            fill_val_next = {back_reg, fore_reg, tcce_pkg::CHR_SPACE};
                            fill_res_next = 1'b1;
                            swp_addr_next = '0;
                            swp_last_next = ADDR_W'(CELLS - 1);
                            state_next    = S_FILL;
                        end
                        tcce_pkg::ACT_READ:
                        begin
                            rem_next  = cmd.cell_index;
                            qrow_next = '0;
                            if (32'(cmd.cell_index) < CELLS)
                            begin
                                state_next = S_DIV;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_FILL, S_SCROLL:
            begin
                // Write one blank cell and advance the sweep address
                ram_we = 1'b1;
                if (swp_addr_reg == swp_last_reg)
                begin
                    if (state_reg == S_SCROLL || fill_res_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    swp_addr_next = alu_res[ADDR_W-1:0];
                end
            end

            S_PUT:
            begin
                case (code_reg)
                    tcce_pkg::CHR_BS:
                    begin
                        if (col_reg != '0)
                        begin
                            col_w = {1'b0, col_reg} - (COL_W + 1)'(1);
                        end
                    end
                    tcce_pkg::CHR_TAB:
                    begin
                        col_w = ({1'b0, col_reg} + (COL_W + 1)'(tcce_pkg::TAB_STEP))
                                & ~((COL_W + 1)'(tcce_pkg::TAB_STEP - 1));
                    end
                    tcce_pkg::CHR_CR:
                    begin
                        col_w = '0;
                    end
                    tcce_pkg::CHR_LF:
                    begin
                        col_w   = '0;
                        row_inc = 1'b1;
                    end
                    default:
                    begin
                        // Write printable bytes at the cursor, ignore other controls
                        if (code_reg >= tcce_pkg::CHR_SPACE)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cell_addr(row_reg, top_reg, col_reg);
                            ram_wdata = {back_reg, fore_reg, code_reg};
                            col_w     = {1'b0, col_reg} + (COL_W + 1)'(1);
                        end
                    end
                endcase

                // Wrap at the right edge
                if (col_w >= (COL_W + 1)'(COLUMNS))
                begin
                    col_w   = '0;
                    row_inc = 1'b1;
                end
                col_next   = col_w[COL_W-1:0];
                state_next = S_DONE;

                // Step the row, scroll past the bottom
                if (row_inc)
                begin
                    if (row_reg == ROW_W'(ROWS - 1))
                    begin
                        fill_val_next = {back_reg, fore_reg, tcce_pkg::CHR_SPACE};
                        swp_addr_next = scroll_base;
                        swp_last_next = scroll_base + ADDR_W'(COLUMNS - 1);
                        if (top_reg == ROW_W'(ROWS - 1))
                        begin
                            top_next = '0;
                        end
                        else
                        begin
                            top_next = top_reg + ROW_W'(1);
                        end
                        state_next = S_SCROLL;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
            end

            S_DIV:
            begin
                // Peel one row off the linear index per cycle
                alu_op = tcce_pkg::ALU_SUB;
                alu_a  = ALU_W'(rem_reg);
                alu_b  = ALU_W'(COLUMNS);
                if (alu_ge)
                begin
                    rem_next  = alu_res[tcce_pkg::INDEX_W-1:0];
                    qrow_next = qrow_reg + ROW_W'(1);
                end
                else
                begin
                    state_next = S_RD_ADDR;
                end
            end

            S_RD_ADDR:
            begin
                state_next = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                res_data_next = ram_rdata;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = tcce_pkg::POS_W'(pos_full);
                    out_data_next  = res_data_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            col_reg       <= '0;
            row_reg       <= '0;
            top_reg       <= '0;
            fore_reg      <= tcce_pkg::FORE_RESET;
            back_reg      <= tcce_pkg::BACK_RESET;
            fill_val_reg  <= tcce_pkg::RESET_CELL;
            fill_res_reg  <= 1'b0;
            code_reg      <= '0;
            rem_reg       <= '0;
            qrow_reg      <= '0;
            swp_addr_reg  <= '0;
            swp_last_reg  <= ADDR_W'(CELLS - 1);
            res_data_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_pos_reg   <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            top_reg       <= top_next;
            fore_reg      <= fore_next;
            back_reg      <= back_next;
            fill_val_reg  <= fill_val_next;
            fill_res_reg  <= fill_res_next;
            code_reg      <= code_next;
            rem_reg       <= rem_next;
            qrow_reg      <= qrow_next;
            swp_addr_reg  <= swp_addr_next;
            swp_last_reg  <= swp_last_next;
            res_data_reg  <= res_data_next;
            out_valid_reg <= out_valid_next;
            out_pos_reg   <= out_pos_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Cursor and row offset stay on the screen
    `TCCE_ASSERT_NOW(a_row_range, 1'b1, 32'(row_reg) < ROWS)
    `TCCE_ASSERT_NOW(a_col_range, 1'b1, 32'(col_reg) < COLUMNS)
    `TCCE_ASSERT_NOW(a_top_range, 1'b1, 32'(top_reg) < ROWS)
    // A taken request keeps the block busy in the next cycle
    `TCCE_ASSERT_NEXT(a_busy_after_req, cmd_fire, !cmd.ready)
    // Cell writes come only from the sweeps or a put
    `TCCE_ASSERT_NOW(a_write_states, ram_we,
        state_reg == S_FILL || state_reg == S_SCROLL || state_reg == S_PUT)

endmodule

FILE: tb/tcce_screen_checker.sv
// Shadow-screen predictor and result comparator for the text console character engine.
`timescale 1ns / 1ps

module tcce_screen_checker
    import tcce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tcce_cmd_if                  cmd,
    tcce_rsp_if                  rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   result_count,
    output int                   scroll_count
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COL_W      = $clog2(COLUMNS + TAB_STEP + 1);
    localparam int ROW_W      = $clog2(ROWS + 1);

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
    } console_result_t;

    // Shadow copy of the cell store, cursor and colors
    logic [CELL_W-1:0]  shadow_screen [CELL_COUNT];
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;

    console_result_t    expected_q [$];

    // Apply one request to the shadow state and work out its result
    task automatic predict_request(
        input  logic [ACTION_W-1:0] action,
        input  logic [CHAR_W-1:0]   code,
        input  logic [INDEX_W-1:0]  index,
        output console_result_t     res
    );
        int unsigned pos;
        logic [CELL_W-1:0] blank;
        blank = {back, fore, CHR_SPACE};
        res.cell_data = '0;
        case (action)
            ACT_PUT:
            begin
                case (code)
                    CHR_BS:
                    begin
                        // no reverse wrap at the left edge
                        if (cur_col != 0)
                            cur_col = cur_col - 1'b1;
                    end
                    CHR_TAB:  cur_col = COL_W'((cur_col + TAB_STEP) & ~(TAB_STEP - 1));
                    CHR_CR:   cur_col = '0;
                    CHR_LF:
                    begin
                        cur_col = '0;
                        cur_row = cur_row + 1'b1;
                    end
                    default:
                    begin
                        // printable bytes land at the cursor, other control bytes drop
                        if (code >= CHR_SPACE)
                        begin
                            pos = cur_row * COLUMNS + cur_col;
                            if (pos < CELL_COUNT)
                                shadow_screen[pos] = {back, fore, code};
                            cur_col = cur_col + 1'b1;
                        end
                    end
                endcase
                if (cur_col >= COLUMNS)
                begin
                    cur_col = '0;
                    cur_row = cur_row + 1'b1;
                end
                // scroll up one line and blank the new bottom line
                if (cur_row >= ROWS)
                begin
                    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                        shadow_screen[i] = shadow_screen[i + COLUMNS];
                    for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++)
                        shadow_screen[i] = blank;
                    cur_row = ROW_W'(ROWS - 1);
                    scroll_count++;
                end
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < CELL_COUNT; i++)
                    shadow_screen[i] = blank;
                cur_col = '0;
                cur_row = '0;
            end
            ACT_READ:
            begin
                if (index < CELL_COUNT)
                    res.cell_data = shadow_screen[index];
            end
            default: ;
        endcase
        pos = cur_row * COLUMNS + cur_col;
        res.cursor_pos = pos[POS_W-1:0];
    endtask

    // Compare results against the oldest prediction, then track config and requests
    always @(posedge clk or negedge rst_n)
    begin : result_compare
        console_result_t want;
        console_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
                shadow_screen[i] = RESET_CELL;
            cur_col = '0;
            cur_row = '0;
            fore    = FORE_RESET;
            back    = BACK_RESET;
            expected_q.delete();
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.cursor_pos = rsp.cursor_pos;
                got.cell_data  = rsp.cell_data;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: cursor_pos %0d cell_data 0x%04h",
                           got.cursor_pos, got.cell_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    result_count++;
                    if (got.cursor_pos !== want.cursor_pos)
                    begin
                        $error("cursor_pos mismatch: expected %0d, actual %0d",
                               want.cursor_pos, got.cursor_pos);
                        fail_count++;
                    end
                    if (got.cell_data !== want.cell_data)
                    begin
                        $error("cell_data mismatch: expected 0x%04h, actual 0x%04h",
                               want.cell_data, got.cell_data);
                        fail_count++;
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FORE: fore = cfg_data;
                    CFG_BACK: back = cfg_data;
                    default: ;
                endcase
            end

            if (cmd.valid && cmd.ready)
            begin
                predict_request(cmd.action, cmd.char_code, cmd.cell_index, want);
                expected_q.push_back(want);
            end

            pending = expected_q.size();
        end
    end

endmodule

FILE: tb/tb_text_console_character_engine.sv
// Stimulus, handshake pacing and verdict for the text console character engine.
`timescale 1ns / 1ps

module tb_text_console_character_engine;
    import tcce_pkg::*;

    // Action code the block leaves unused
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    localparam int PHASE_ITEMS = 230;
    localparam int PHASES      = 6;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [CHAR_W-1:0]   char_code;
        logic [INDEX_W-1:0]  cell_index;
    } console_request_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int scroll_count;

    console_request_t request_q [$];
    bit               tx_busy;
    int               rx_hold;
    int               put_count;
    int               read_count;
    int               clear_count;
    int               unused_count;
    int               color_settings;

    tcce_cmd_if cmd();
    tcce_rsp_if rsp();

    text_console_character_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tcce_screen_checker #(
        .COLUMNS (COLUMNS_DEF),
        .ROWS    (ROWS_DEF)
    ) u_screen_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rsp          (rsp),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .scroll_count (scroll_count)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Bound the run in case the block hangs
    initial
    begin
        #20_000_000;
        $display("timeout: requests or results stopped moving");
        $display("*** FAILED ***");
        $finish;
    end

    // Queue one request for the driver and tally it by kind
    task automatic queue_request(
        input logic [ACTION_W-1:0] action,
        input logic [CHAR_W-1:0]   code,
        input logic [INDEX_W-1:0]  index
    );
        console_request_t req;
        req.action     = action;
        req.char_code  = code;
        req.cell_index = index;
        request_q.push_back(req);
        case (action)
            ACT_PUT:   put_count++;
            ACT_READ:  read_count++;
            ACT_CLEAR: clear_count++;
            default:   unused_count++;
        endcase
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] code);
        queue_request(ACT_PUT, code, INDEX_W'($urandom));
    endtask

    task automatic read_cell(input logic [INDEX_W-1:0] index);
        queue_request(ACT_READ, CHAR_W'($urandom), index);
    endtask

    // Hold until every request is sent and every result is back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_q.size() != 0 || tx_busy || pending != 0);
        @(posedge clk);
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FORE;
        cfg_data  <= fg;
        @(posedge clk);
        cfg_index <= CFG_BACK;
        cfg_data  <= bg;
        @(posedge clk);
        cfg_we    <= 1'b0;
        color_settings++;
    endtask

    // Build one phase of mostly well-formed text with reads and noise mixed in
    task automatic queue_random_phase(input int budget);
        int start;
        int pick;
        int len;
        int tail;
        bit wide;
        start = put_count + read_count + clear_count + unused_count;
        while (put_count + read_count + clear_count + unused_count - start < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                // text line, sometimes long enough to wrap
                wide = ($urandom_range(0, 9) == 0);
                len  = wide ? $urandom_range(70, 90) : $urandom_range(0, 40);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 23))
                        0:       put_char(CHR_BS);
                        1:       put_char(CHR_TAB);
                        default: put_char(CHAR_W'($urandom_range(32, 255)));
                    endcase
                end
                tail = $urandom_range(0, 9);
                if (wide && tail < 4)
                    put_char(CHR_TAB);
                else if (tail < 5)
                begin
                    put_char(CHR_CR);
                    put_char(CHR_LF);
                end
                else if (tail < 8)
                    put_char(CHR_LF);
                else if (tail < 9)
                    put_char(CHR_TAB);
            end
            else if (pick < 75)
            begin
                if ($urandom_range(0, 9) == 0)
                    read_cell(INDEX_W'($urandom_range(2000, 2047)));
                else
                    read_cell(INDEX_W'($urandom_range(0, 1999)));
            end
            else if (pick < 85)
                put_char(CHAR_W'($urandom_range(0, 31)));
            else if (pick < 90)
                queue_request(ACTION_W'($urandom_range(0, 3)), CHAR_W'($urandom),
                              INDEX_W'($urandom_range(0, 2047)));
            else if (pick < 98)
            begin
                // burst of line feeds to force scrolling
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    put_char(CHR_LF);
            end
            else if ($urandom_range(0, 3) == 0)
                queue_request(ACT_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
            else
                read_cell(INDEX_W'($urandom_range(0, 1999)));
        end
    endtask

    // Request driver: pops queued requests and paces them with random gaps
    initial
    begin : request_driver
        console_request_t req;
        int  gap;
        int  run_left;
        bit  calm;
        run_left      = 0;
        calm          = 1'b0;
        tx_busy       = 1'b0;
        cmd.valid     = 1'b0;
        cmd.action    = ACT_PUT;
        cmd.char_code = '0;
        cmd.cell_index = '0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (request_q.size() == 0)
            begin
                cmd.valid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                req     = request_q.pop_front();
                tx_busy = 1'b1;
                if (run_left == 0)
                begin
                    run_left = $urandom_range(10, 60);
                    calm     = ($urandom_range(0, 3) == 0);
                end
                run_left--;
                gap = calm ? 0 : $urandom_range(0, 13);
                if (gap > 0)
                begin
                    cmd.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                cmd.valid      <= 1'b1;
                cmd.action     <= req.action;
                cmd.char_code  <= req.char_code;
                cmd.cell_index <= req.cell_index;
                do
                    @(posedge clk);
                while (!cmd.ready);
                tx_busy = 1'b0;
            end
        end
    end

    // Result acceptor: random stalls, calm stretches and one long hold-off
    initial
    begin : result_acceptor
        int  stall;
        int  run_left;
        bit  calm;
        run_left  = 0;
        calm      = 1'b0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(10, 60);
                    calm     = ($urandom_range(0, 3) == 0);
                end
                run_left--;
                stall = calm ? 0 : $urandom_range(0, 13);
            end
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
        end
    end

    // Main sequence: reset, directed requests, then color phases of random traffic
    initial
    begin : main_sequence
        logic [COLOR_W-1:0] fg_list [PHASES];
        logic [COLOR_W-1:0] bg_list [PHASES];
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_FORE;
        cfg_data       = '0;
        rx_hold        = 0;
        color_settings = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset contents, range edges, every handled control byte, other controls and every action
        read_cell(11'd0);
        put_char(8'h48);
        put_char(8'hFF);
        put_char(CHR_SPACE);
        read_cell(11'd1);
        read_cell(11'd2);
        put_char(CHR_BS);
        put_char(CHR_BS);
        put_char(CHR_BS);
        put_char(CHR_BS);
        put_char(CHR_TAB);
        put_char(8'h7E);
        put_char(CHR_TAB);
        put_char(CHR_CR);
        put_char(CHR_LF);
        put_char(8'h00);
        put_char(8'h1F);
        put_char(8'h0B);
        read_cell(11'd1999);
        read_cell(11'd2000);
        read_cell(11'd2047);
        queue_request(ACT_NONE, 8'hFF, 11'h7FF);
        queue_request(ACT_CLEAR, 8'h00, 11'h000);
        read_cell(11'd0);
        wait_idle();

        fg_list = '{4'h0, 4'hF, COLOR_W'($urandom), 4'hF, 4'h0, COLOR_W'($urandom)};
        bg_list = '{4'h0, 4'hF, COLOR_W'($urandom), 4'h0, 4'hF, COLOR_W'($urandom)};
        for (int p = 0; p < PHASES; p++)
        begin
            set_colors(fg_list[p], bg_list[p]);
            // back up the result side so the block stalls its request side
            if (p == 1)
                rx_hold = LONG_HOLD;
            queue_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        // Let any stray result show up before the verdict
        repeat (ROWS_DEF * COLUMNS_DEF + 64) @(posedge clk);
        if (pending != 0)
            $error("%0d results never arrived", pending);

        $display("Covered %0d requests: %0d puts, %0d reads, %0d clears, %0d unused codes",
                 put_count + read_count + clear_count + unused_count,
                 put_count, read_count, clear_count, unused_count);
        $display("Checked %0d results across %0d color settings with %0d scrolls",
                 result_count, color_settings, scroll_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
